// File: sv/rnb_pkg.sv
// ----------------------------------------------------------------------------
// rnb_pkg
// Shared types, constants and helpers for the radix-4 NTT butterfly.
// ----------------------------------------------------------------------------
package rnb_pkg;

  localparam int unsigned DataW    = 64;
  localparam int unsigned HalfW    = DataW / 2;
  localparam int unsigned ModW     = 62;
  localparam int unsigned WordBits = 64;   // shift applied to the full Shoup product
  localparam int unsigned ShoupLat = 4;    // pipeline depth of one Shoup multiplier
  localparam int unsigned Latency  = 11;   // valid-line stages from accept to the result register
  localparam int unsigned AddrW    = 5;
  localparam int unsigned ApbW     = 64;

  typedef logic [DataW-1:0] word_t;

  typedef enum logic [1:0] {
    RegModulus    = 2'd0,
    RegRootJ      = 2'd1,
    RegRootJShoup = 2'd2
  } reg_idx_e;

  // twiddles travelling alongside the butterfly core
  typedef struct packed {
    logic  general;
    word_t tw1;
    word_t tw1_shoup;
    word_t tw2;
    word_t tw2_shoup;
    word_t tw3;
    word_t tw3_shoup;
  } twid_t;

  // conditional subtraction of 2p
  function automatic word_t fold2p(word_t u, word_t d);
    return (u < d) ? u : u - d;
  endfunction

  function automatic logic [DataW-1:0] mul32(logic [HalfW-1:0] a, logic [HalfW-1:0] b);
    return DataW'(a) * DataW'(b);
  endfunction

  function automatic logic [HalfW-1:0] mul32lo(logic [HalfW-1:0] a, logic [HalfW-1:0] b);
    return HalfW'(mul32(a, b));
  endfunction

endpackage

// File: sv/radix4_ntt_butterfly.sv
// ----------------------------------------------------------------------------
// radix4_ntt_butterfly
// Pipelined radix-4 NTT butterfly with lazy reduction and Shoup multiplies.
// ----------------------------------------------------------------------------
// usage
//   config: APB-style port, 64-bit data; modulus at 0x00, root_j at 0x08,
//   root_j_shoup at 0x10; paddr[2:0] is ignored, index 3 (0x18) writes
//   nothing and reads zero; write these only while no beat is in flight
//   input: a beat is taken at each rising edge with start high and busy
//   low; busy is tied low, so a new beat may enter every cycle
//   output: each result beat shows on out0_o..out3_o for one cycle with
//   done_o high, at the end of the 11 register stages; results keep
//   input order
//   latency is set by two chained Shoup multipliers (j rotation, then the
//   twiddles), four stages each, plus the add/fold stages around them
//   throughput: one butterfly per cycle, sustained
//   reset: clears the valid line and the config registers (modulus = 2);
//   beats in flight are dropped
//   the receiver cannot stall: results are not held, only strobed
// ----------------------------------------------------------------------------
module radix4_ntt_butterfly (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type_i,
  input  rnb_pkg::word_t            coef0_i,
  input  rnb_pkg::word_t            coef1_i,
  input  rnb_pkg::word_t            coef2_i,
  input  rnb_pkg::word_t            coef3_i,
  input  rnb_pkg::word_t            tw1_i,
  input  rnb_pkg::word_t            tw1_shoup_i,
  input  rnb_pkg::word_t            tw2_i,
  input  rnb_pkg::word_t            tw2_shoup_i,
  input  rnb_pkg::word_t            tw3_i,
  input  rnb_pkg::word_t            tw3_shoup_i,
  // result channel
  output logic                      done_o,
  output rnb_pkg::word_t            out0_o,
  output rnb_pkg::word_t            out1_o,
  output rnb_pkg::word_t            out2_o,
  output rnb_pkg::word_t            out3_o,
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rnb_pkg::AddrW-1:0] paddr,
  input  logic [rnb_pkg::ApbW-1:0]  pwdata,
  output logic [rnb_pkg::ApbW-1:0]  prdata,
  output logic                      pready
);

  import rnb_pkg::*;

  localparam int unsigned FoldW = 3 * DataW + 1;

  // config registers
  logic [ModW-1:0] modulus_q, root_j_q;
  word_t           root_j_shoup_q;
  word_t           p_word, d2p;
  logic [1:0]      reg_sel;

  // valid line, one bit per stage
  logic [Latency-1:0] valid_q;
  logic               accept;

  // butterfly core stages
  word_t v02_q, v13_q, sum02_q, sum13_q;   // stage 1
  word_t s02_q, s13_q;                     // stage 2
  word_t t0_sum_q, t2_q;                   // stage 3
  word_t a_q, b_q;                         // stage 6
  word_t out0_q, out1_q, out2_q, out3_q;   // stage 11

  word_t a0_s5, jt_s5, t2_s6, t0_s10;
  word_t m1_s10, m2_s10, m3_s10;
  twid_t tw_in, tw_s6;
  logic [FoldW-1:0] fold_in, fold_s10;
  logic  general_s10;
  word_t fa_s10, ft2_s10, fb_s10;

  assign p_word  = {{(DataW-ModW){1'b0}}, modulus_q};
  assign d2p     = {{(DataW-ModW-1){1'b0}}, modulus_q, 1'b0};
  assign reg_sel = paddr[AddrW-1:3];

  // ---------------------------------------------------------------------------
  // config port: no wait states
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q      <= ModW'(2);
      root_j_q       <= '0;
      root_j_shoup_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        RegModulus:    modulus_q      <= pwdata[ModW-1:0];
        RegRootJ:      root_j_q       <= pwdata[ModW-1:0];
        RegRootJShoup: root_j_shoup_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegModulus:    prdata = {{(ApbW-ModW){1'b0}}, modulus_q};
      RegRootJ:      prdata = {{(ApbW-ModW){1'b0}}, root_j_q};
      RegRootJShoup: prdata = root_j_shoup_q;
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake and valid line; the pipeline never stalls
  // ---------------------------------------------------------------------------
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Latency-2:0], accept};
    end
  end

  assign done_o = valid_q[Latency-1];

  // ---------------------------------------------------------------------------
  // stages 1-4: even/odd sums and differences
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // stage 1: raw sums and 2p-offset differences
    v02_q    <= coef0_i - coef2_i + d2p;
    v13_q    <= coef1_i - coef3_i + d2p;
    sum02_q  <= coef0_i + coef2_i;
    sum13_q  <= coef1_i + coef3_i;
    // stage 2: fold the even/odd sums
    s02_q    <= fold2p(sum02_q, d2p);
    s13_q    <= fold2p(sum13_q, d2p);
    // stage 3: second-level sum and difference
    t0_sum_q <= s02_q + s13_q;
    t2_q     <= s02_q - s13_q + d2p;
  end

  // folded x0 term waits for the j product (stage 1 -> 5)
  rnb_delay #(.WIDTH(DataW), .DEPTH(4)) u_dly_a0 (
    .clk_i (clk_i),
    .d_i   (fold2p(v02_q, d2p)),
    .q_o   (a0_s5)
  );

  // odd difference times j, Shoup style (stage 1 -> 5)
  rnb_shoup_mul u_mul_j (
    .clk_i (clk_i),
    .x_i   (v13_q),
    .y_i   ({{(DataW-ModW){1'b0}}, root_j_q}),
    .ys_i  (root_j_shoup_q),
    .p_i   (p_word),
    .r_o   (jt_s5)
  );

  // out0 folds at stage 4 and waits for the twiddle products
  rnb_delay #(.WIDTH(DataW), .DEPTH(7)) u_dly_t0 (
    .clk_i (clk_i),
    .d_i   (fold2p(t0_sum_q, d2p)),
    .q_o   (t0_s10)
  );

  // even difference lines up with the j-butterfly outputs (stage 3 -> 6)
  rnb_delay #(.WIDTH(DataW), .DEPTH(3)) u_dly_t2 (
    .clk_i (clk_i),
    .d_i   (t2_q),
    .q_o   (t2_s6)
  );

  // ---------------------------------------------------------------------------
  // stage 6: j-butterfly sum and difference
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    a_q <= a0_s5 + jt_s5;
    b_q <= a0_s5 - jt_s5 + d2p;
  end

  // twiddles and mode ride along to stage 6
  always_comb begin
    tw_in.general   = req_type_i;
    tw_in.tw1       = tw1_i;
    tw_in.tw1_shoup = tw1_shoup_i;
    tw_in.tw2       = tw2_i;
    tw_in.tw2_shoup = tw2_shoup_i;
    tw_in.tw3       = tw3_i;
    tw_in.tw3_shoup = tw3_shoup_i;
  end

  rnb_delay #(.WIDTH($bits(twid_t)), .DEPTH(6)) u_dly_tw (
    .clk_i (clk_i),
    .d_i   (tw_in),
    .q_o   (tw_s6)
  );

  // ---------------------------------------------------------------------------
  // stages 7-10: twiddle products (general mode) and final folds (unit mode)
  // ---------------------------------------------------------------------------
  rnb_shoup_mul u_mul_w1 (
    .clk_i (clk_i),
    .x_i   (a_q),
    .y_i   (tw_s6.tw1),
    .ys_i  (tw_s6.tw1_shoup),
    .p_i   (p_word),
    .r_o   (m1_s10)
  );

  rnb_shoup_mul u_mul_w2 (
    .clk_i (clk_i),
    .x_i   (t2_s6),
    .y_i   (tw_s6.tw2),
    .ys_i  (tw_s6.tw2_shoup),
    .p_i   (p_word),
    .r_o   (m2_s10)
  );

  rnb_shoup_mul u_mul_w3 (
    .clk_i (clk_i),
    .x_i   (b_q),
    .y_i   (tw_s6.tw3),
    .ys_i  (tw_s6.tw3_shoup),
    .p_i   (p_word),
    .r_o   (m3_s10)
  );

  assign fold_in = {tw_s6.general, fold2p(a_q, d2p), fold2p(t2_s6, d2p), fold2p(b_q, d2p)};

  rnb_delay #(.WIDTH(FoldW), .DEPTH(ShoupLat)) u_dly_fold (
    .clk_i (clk_i),
    .d_i   (fold_in),
    .q_o   (fold_s10)
  );

  assign {general_s10, fa_s10, ft2_s10, fb_s10} = fold_s10;

  // ---------------------------------------------------------------------------
  // stage 11: output register, mode select
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    out0_q <= t0_s10;
    out1_q <= general_s10 ? m1_s10 : fa_s10;
    out2_q <= general_s10 ? m2_s10 : ft2_s10;
    out3_q <= general_s10 ? m3_s10 : fb_s10;
  end

  assign out0_o = out0_q;
  assign out1_o = out1_q;
  assign out2_o = out2_q;
  assign out3_o = out3_q;

`ifndef ASSERT_OFF
  // every accepted beat comes out after the fixed pipeline latency
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted beat did not produce a result on time");

  // no result strobe without a matching accept
  a_done_has_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result strobe without a matching accepted beat");
`endif

endmodule

// File: sv/rnb_delay.sv
// ----------------------------------------------------------------------------
// rnb_delay
// Fixed-depth shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module rnb_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int unsigned i = 1; i < DEPTH; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

// File: sv/rnb_shoup_mul.sv
// ----------------------------------------------------------------------------
// rnb_shoup_mul
// Four-stage Shoup multiplier: r = x*y - hi(x*ys)*p, all modulo 2^64.
// ----------------------------------------------------------------------------
module rnb_shoup_mul (
  input  logic          clk_i,
  input  rnb_pkg::word_t x_i,
  input  rnb_pkg::word_t y_i,
  input  rnb_pkg::word_t ys_i,
  input  rnb_pkg::word_t p_i,
  output rnb_pkg::word_t r_o
);

  import rnb_pkg::*;

  // stage 1: partial products
  logic [DataW-1:0]   xs_ll_q, xs_lh_q, xs_hl_q, xs_hh_q, xy_ll_q;
  logic [HalfW-1:0]   xy_lh_q, xy_hl_q;
  // stage 2: quotient estimate and low product
  word_t              q_q, xy_q;
  // stage 3: q*p partials
  logic [DataW-1:0]   qp_ll_q;
  logic [HalfW-1:0]   qp_lh_q, qp_hl_q;
  word_t              xy2_q;
  // stage 4: result
  word_t              r_q;

  logic [2*DataW-1:0] xs_prod;
  word_t              xy_lo, qp_lo;
  logic [HalfW-1:0]   xy_mid, qp_mid;

  always_comb begin
    xs_prod = {{DataW{1'b0}}, xs_ll_q}
            + {{HalfW{1'b0}}, xs_lh_q, {HalfW{1'b0}}}
            + {{HalfW{1'b0}}, xs_hl_q, {HalfW{1'b0}}}
            + {xs_hh_q, {DataW{1'b0}}};
    xy_mid  = xy_lh_q + xy_hl_q;
    xy_lo   = xy_ll_q + {xy_mid, {HalfW{1'b0}}};
    qp_mid  = qp_lh_q + qp_hl_q;
    qp_lo   = qp_ll_q + {qp_mid, {HalfW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    xs_ll_q <= mul32(x_i[HalfW-1:0],     ys_i[HalfW-1:0]);
    xs_lh_q <= mul32(x_i[HalfW-1:0],     ys_i[DataW-1:HalfW]);
    xs_hl_q <= mul32(x_i[DataW-1:HalfW], ys_i[HalfW-1:0]);
    xs_hh_q <= mul32(x_i[DataW-1:HalfW], ys_i[DataW-1:HalfW]);
    xy_ll_q <= mul32(x_i[HalfW-1:0],     y_i[HalfW-1:0]);
    xy_lh_q <= mul32lo(x_i[HalfW-1:0],   y_i[DataW-1:HalfW]);
    xy_hl_q <= mul32lo(x_i[DataW-1:HalfW], y_i[HalfW-1:0]);

    q_q     <= xs_prod[WordBits +: DataW];
    xy_q    <= xy_lo;

    qp_ll_q <= mul32(q_q[HalfW-1:0],     p_i[HalfW-1:0]);
    qp_lh_q <= mul32lo(q_q[HalfW-1:0],   p_i[DataW-1:HalfW]);
    qp_hl_q <= mul32lo(q_q[DataW-1:HalfW], p_i[HalfW-1:0]);
    xy2_q   <= xy_q;

    r_q     <= xy2_q - qp_lo;
  end

  assign r_o = r_q;

endmodule
